### design/pwd_pkg.sv
`timescale 1ns / 1ps
// Package for the path waypoint decimator: payload structs, register
// indexes, sequencer states and sizing constants. No dependencies.
package pwd_pkg;

  // Coordinate format: signed fixed point with 8 fraction bits
  localparam int COORD_WIDTH = 24;
  localparam int SUM_WIDTH   = 32;

  // Register widths and reset values
  localparam int                  CFG_DATA_W        = 32;
  localparam int                  CFG_INDEX_W       = 2;
  localparam logic [31:0]         SPACING_RESET     = 32'd1920;  // 7.5 m
  localparam logic [7:0]          WP_LIMIT_RESET    = 8'd4;
  localparam logic                PAD_RESET         = 1'b1;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SPACING_LIMIT  = 2'd0,
    CFG_WAYPOINT_LIMIT = 2'd1,
    CFG_PAD_WITH_GOAL  = 2'd2
  } cfg_index_t;

  // One incoming path point
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          last_point;
  } point_t;

  // One outgoing waypoint or end marker
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] wp_x;
    logic signed [COORD_WIDTH-1:0] wp_y;
    logic signed [COORD_WIDTH-1:0] wp_z;
    logic [7:0]                    waypoint_index;
    logic                          from_goal;
    logic                          has_point;
    logic                          end_of_path;
  } waypoint_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_UPDATE,
    ST_EMIT
  } state_t;

endpackage

### design/path_waypoint_decimator_top.sv
`timescale 1ns / 1ps
// Top level of the path waypoint decimator: sequencer, distance datapath,
// result buffer and output register. Uses pwd_pkg and pwd_sqrt.
//
// Resamples a stream of 3D path points into waypoints by arc length. A point
// that continues a path goes through accept, difference/square accumulation
// on one multiplier, square root start, the bit-serial square root, update,
// and one emit per result; each emit waits while the receiver stalls the
// output register. The first point of a path skips the distance work and
// goes from accept straight to update. One point is in work at a time; the
// next point is taken while the last result still waits in the output
// register. Configuration writes take effect at once and belong between
// points. Results per point: none, one, or two.
module path_waypoint_decimator_top #(
  parameter int SUM_WIDTH = pwd_pkg::SUM_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              point_valid,
  output logic                              point_ready,
  input  pwd_pkg::point_t                   point_data,
  output logic                              wp_valid,
  input  logic                              wp_ready,
  output pwd_pkg::waypoint_t                wp_data,
  input  logic                              cfg_we,
  input  logic [pwd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pwd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW    = pwd_pkg::COORD_WIDTH;
  localparam int MW    = CW + 1;                      // difference magnitude
  localparam int QW    = 2 * MW;                      // sum of three squares
  localparam int QS    = (QW > 64) ? 64 : QW;         // saturated square sum
  localparam int RW    = QS / 2;                      // segment length
  localparam int EW    = ((RW > SUM_WIDTH) ? RW : SUM_WIDTH) + 1;
  localparam int CMP_W = (SUM_WIDTH > 32) ? SUM_WIDTH : 32;

  // Configuration registers
  logic [31:0] spacing_limit;
  logic [7:0]  waypoint_limit;
  logic        pad_with_goal;

  // Path state
  logic [CW-1:0]        prev_x, prev_y, prev_z;
  logic [SUM_WIDTH-1:0] spacing_sum;
  logic [7:0]           wp_count;
  logic                 path_started;

  // Sequencer and datapath
  pwd_pkg::state_t    state, state_next;
  pwd_pkg::point_t    cur;
  logic [2:0]         step;
  logic [MW-1:0]      mag;
  logic [QW-1:0]      sq;
  logic [QW-1:0]      acc;
  logic [QS-1:0]      qsat;
  logic               sq_start;
  logic               sq_done;
  logic [RW-1:0]      seg;

  // Result buffer
  pwd_pkg::waypoint_t pend0, pend1;
  logic               pend_two;
  logic               pend_sel;
  logic               out_load;

  // Update results
  logic signed [MW-1:0] diff;
  logic [EW-1:0]        seg_w, sum_w, smax_w;
  logic [SUM_WIDTH-1:0] seg_sat, sum_new, sum_a;
  logic [7:0]           cnt_a;
  logic                 emit_mid, goal_ok, n_any, n_two;
  pwd_pkg::waypoint_t   r0, r1, goal_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing_limit  <= pwd_pkg::SPACING_RESET;
      waypoint_limit <= pwd_pkg::WP_LIMIT_RESET;
      pad_with_goal  <= pwd_pkg::PAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pwd_pkg::CFG_SPACING_LIMIT:  spacing_limit  <= cfg_data[31:0];
        pwd_pkg::CFG_WAYPOINT_LIMIT: waypoint_limit <= cfg_data[7:0];
        pwd_pkg::CFG_PAD_WITH_GOAL:  pad_with_goal  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Coordinate difference for the axis picked by step
  always_comb begin
    case (step)
      3'd0:    diff = MW'($signed(cur.point_x)) - MW'($signed(prev_x));
      3'd1:    diff = MW'($signed(cur.point_y)) - MW'($signed(prev_y));
      3'd2:    diff = MW'($signed(cur.point_z)) - MW'($signed(prev_z));
      default: diff = '0;
    endcase
  end

  // Square sum saturates to QS bits (at most 64; equal to QW at the default width)
  assign qsat = ((acc >> QS) != '0) ? '1 : QS'(acc);

  pwd_sqrt #(
    .IN_W (QS)
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (qsat),
    .done    (sq_done),
    .root    (seg)
  );

  // Waypoint decision for the current point
  always_comb begin
    smax_w  = EW'({SUM_WIDTH{1'b1}});
    seg_w   = EW'(seg);
    seg_sat = (seg_w > smax_w) ? {SUM_WIDTH{1'b1}} : SUM_WIDTH'(seg_w);
    sum_w   = EW'(spacing_sum) + EW'(seg_sat);
    sum_new = (sum_w > smax_w) ? {SUM_WIDTH{1'b1}} : SUM_WIDTH'(sum_w);

    r0       = '0;
    r1       = '0;
    emit_mid = 1'b0;
    cnt_a    = wp_count;
    sum_a    = sum_new;
    if (!path_started) begin
      r0.wp_x      = cur.point_x;
      r0.wp_y      = cur.point_y;
      r0.wp_z      = cur.point_z;
      r0.has_point = 1'b1;
      emit_mid     = 1'b1;
      cnt_a        = 8'd1;
      sum_a        = '0;
    end else if ((CMP_W'(sum_new) > CMP_W'(spacing_limit)) &&
                 (wp_count < waypoint_limit)) begin
      r0.wp_x           = prev_x;
      r0.wp_y           = prev_y;
      r0.wp_z           = prev_z;
      r0.waypoint_index = wp_count;
      r0.has_point      = 1'b1;
      emit_mid          = 1'b1;
      cnt_a             = 8'(wp_count + 8'd1);
      sum_a             = seg_sat;
    end

    goal_r                = '0;
    goal_r.wp_x           = cur.point_x;
    goal_r.wp_y           = cur.point_y;
    goal_r.wp_z           = cur.point_z;
    goal_r.waypoint_index = cnt_a;
    goal_r.from_goal      = 1'b1;
    goal_r.has_point      = 1'b1;
    goal_r.end_of_path    = 1'b1;
    goal_ok = (cnt_a < waypoint_limit) && pad_with_goal;

    n_any = emit_mid;
    n_two = 1'b0;
    if (cur.last_point) begin
      n_any = 1'b1;
      if (goal_ok) begin
        if (emit_mid) begin
          r1    = goal_r;
          n_two = 1'b1;
        end else begin
          r0 = goal_r;
        end
      end else if (emit_mid) begin
        r0.end_of_path = 1'b1;
      end else begin
        // bare end marker
        r0.waypoint_index = cnt_a;
        r0.end_of_path    = 1'b1;
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pwd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next  = state;
    point_ready = 1'b0;
    sq_start    = 1'b0;
    out_load    = 1'b0;
    case (state)
      pwd_pkg::ST_IDLE: begin
        point_ready = 1'b1;
        if (point_valid) begin
          state_next = path_started ? pwd_pkg::ST_DIFF : pwd_pkg::ST_UPDATE;
        end
      end
      pwd_pkg::ST_DIFF: begin
        if (step == 3'd4) begin
          state_next = pwd_pkg::ST_SQRT_GO;
        end
      end
      pwd_pkg::ST_SQRT_GO: begin
        sq_start   = 1'b1;
        state_next = pwd_pkg::ST_SQRT_WAIT;
      end
      pwd_pkg::ST_SQRT_WAIT: begin
        if (sq_done) begin
          state_next = pwd_pkg::ST_UPDATE;
        end
      end
      pwd_pkg::ST_UPDATE: begin
        state_next = n_any ? pwd_pkg::ST_EMIT : pwd_pkg::ST_IDLE;
      end
      pwd_pkg::ST_EMIT: begin
        if (!wp_valid || wp_ready) begin
          out_load = 1'b1;
          if (pend_sel == pend_two) begin
            state_next = pwd_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = pwd_pkg::ST_IDLE;
    endcase
  end

  // Path state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x       <= '0;
      prev_y       <= '0;
      prev_z       <= '0;
      spacing_sum  <= '0;
      wp_count     <= '0;
      path_started <= 1'b0;
    end else if (state == pwd_pkg::ST_UPDATE) begin
      if (cur.last_point) begin
        prev_x       <= '0;
        prev_y       <= '0;
        prev_z       <= '0;
        spacing_sum  <= '0;
        wp_count     <= '0;
        path_started <= 1'b0;
      end else begin
        prev_x       <= cur.point_x;
        prev_y       <= cur.point_y;
        prev_z       <= cur.point_z;
        spacing_sum  <= sum_a;
        wp_count     <= cnt_a;
        path_started <= 1'b1;
      end
    end
  end

  // Distance datapath: |d| -> square -> accumulate, one axis per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (point_valid && point_ready) begin
      step <= '0;
    end else if (state == pwd_pkg::ST_DIFF) begin
      step <= 3'(step + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (point_valid && point_ready) begin
      cur <= point_data;
    end
    if (state == pwd_pkg::ST_DIFF) begin
      mag <= diff[MW-1] ? MW'(-diff) : MW'(diff);
      sq  <= QW'(mag) * QW'(mag);
      if (step == 3'd2) begin
        acc <= sq;
      end else begin
        acc <= QW'(acc + sq);
      end
    end
  end

  // Result buffer
  always_ff @(posedge clk) begin
    if (state == pwd_pkg::ST_UPDATE) begin
      pend0    <= r0;
      pend1    <= r1;
      pend_two <= n_two;
      pend_sel <= 1'b0;
    end else if (out_load) begin
      pend_sel <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      wp_valid <= 1'b0;
    end else if (out_load) begin
      wp_valid <= 1'b1;
    end else if (wp_ready) begin
      wp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      wp_data <= pend_sel ? pend1 : pend0;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == pwd_pkg::ST_SQRT_WAIT))
    else $error("square root finished outside its wait state");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    (point_valid && point_ready) |=>
      (state == pwd_pkg::ST_DIFF || state == pwd_pkg::ST_UPDATE))
    else $error("accepted point did not start work");

  a_last_clears_path: assert property (@(posedge clk) disable iff (rst)
    (state == pwd_pkg::ST_UPDATE && cur.last_point) |=>
      (!path_started && wp_count == 8'd0 && spacing_sum == '0))
    else $error("path state not cleared after last point");

endmodule

### design/pwd_sqrt.sv
`timescale 1ns / 1ps
// Iterative integer square root, one result bit per cycle.
// Standalone; instantiated by path_waypoint_decimator_top.
module pwd_sqrt #(
  parameter int IN_W = 50
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IN_W-1:0]   operand,
  output logic              done,
  output logic [IN_W/2-1:0] root
);

  localparam int RW    = IN_W / 2;
  localparam int CNT_W = $clog2(RW);

  logic [IN_W-1:0]  opnd;
  logic [RW:0]      rem;
  logic [RW-1:0]    root_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [RW+1:0]    rem_sh;
  logic [RW+1:0]    trial;
  logic             fits;

  // One digit step: bring down two bits, try (root*4 + 1)
  always_comb begin
    rem_sh = {rem[RW-1:0], opnd[IN_W-1:IN_W-2]};
    trial  = {root_r, 2'b01};
    fits   = (rem_sh >= trial);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= CNT_W'(cnt + 1'b1);
        if (cnt == CNT_W'(RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      opnd   <= operand;
      rem    <= '0;
      root_r <= '0;
    end else if (busy) begin
      opnd <= {opnd[IN_W-3:0], 2'b00};
      if (fits) begin
        rem    <= (RW+1)'(rem_sh - trial);
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem    <= rem_sh[RW:0];
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

  assign root = root_r;

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("sqrt done without a finished run");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("sqrt started while busy");

endmodule

### verif/path_waypoint_decimator_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for path_waypoint_decimator_top: random and directed
// paths, an arc-length waypoint predictor and a field-by-field result checker.
// Depends on pwd_pkg and the decimator RTL only.
module path_waypoint_decimator_top_tb;

  localparam int CW = pwd_pkg::COORD_WIDTH;
  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t COORD_MAX     = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN     = {1'b1, {(CW-1){1'b0}}};
  localparam int     SETTLE_CYCLES = 80;    // > one point's worth of work plus a stall
  localparam int     DRAIN_LIMIT   = 5000;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     PRINT_LIMIT   = 40;

  logic                            clk;
  logic                            rst;
  logic                            point_valid;
  logic                            point_ready;
  pwd_pkg::point_t                 point_data;
  logic                            wp_valid;
  logic                            wp_ready;
  pwd_pkg::waypoint_t              wp_data;
  logic                            cfg_we;
  logic [pwd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [pwd_pkg::CFG_DATA_W-1:0]  cfg_data;

  path_waypoint_decimator_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point_data  (point_data),
    .wp_valid    (wp_valid),
    .wp_ready    (wp_ready),
    .wp_data     (wp_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Stimulus and scoreboard storage
  pwd_pkg::point_t    pending_points[$];
  pwd_pkg::waypoint_t expected_wps[$];
  int                 mismatch_count = 0;

  // Handshake pacing
  bit          tx_steady   = 1'b0;
  bit          rx_steady   = 1'b0;
  bit          pt_accepted = 1'b0;
  int unsigned pt_gap      = 0;
  int unsigned rx_wait     = 0;
  int unsigned hold_left   = 0;
  bit          hold_req    = 1'b0;

  // Predictor copy of the registers and path state
  logic [31:0] cur_spacing  = pwd_pkg::SPACING_RESET;
  logic [7:0]  cur_wp_limit = pwd_pkg::WP_LIMIT_RESET;
  logic        cur_pad      = pwd_pkg::PAD_RESET;
  coord_t      last_x = '0, last_y = '0, last_z = '0;
  logic [31:0] path_sum  = '0;
  logic [7:0]  wp_count  = '0;
  bit          path_open = 1'b0;

  // Generator's notion of the previous point
  coord_t gen_x = '0, gen_y = '0, gen_z = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned draw_pause(bit steady);
    return steady ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint unsigned axis_square(coord_t a, coord_t b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return d * d;
  endfunction

  // floor(sqrt(v)), digit by digit
  function automatic longint unsigned seg_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic pwd_pkg::waypoint_t make_wp(coord_t x, coord_t y, coord_t z,
                                                 logic [7:0] idx, logic goal, logic has,
                                                 logic fin);
    pwd_pkg::waypoint_t w;
    w.wp_x           = x;
    w.wp_y           = y;
    w.wp_z           = z;
    w.waypoint_index = idx;
    w.from_goal      = goal;
    w.has_point      = has;
    w.end_of_path    = fin;
    return w;
  endfunction

  function automatic void predict_waypoints(pwd_pkg::point_t p);
    pwd_pkg::waypoint_t outs [2];
    int                 n;
    longint unsigned    seg, run;
    n = 0;
    if (!path_open) begin
      // first point of a path is always waypoint 0
      outs[n] = make_wp(p.point_x, p.point_y, p.point_z, 8'd0, 1'b0, 1'b1, 1'b0);
      n++;
      wp_count  = 8'd1;
      path_sum  = '0;
      path_open = 1'b1;
    end else begin
      // segment length fits 32 bits at this coordinate width
      seg = seg_root(axis_square(p.point_x, last_x) + axis_square(p.point_y, last_y)
                     + axis_square(p.point_z, last_z));
      run = longint'(path_sum) + seg;
      if (run > 64'hFFFF_FFFF) run = 64'hFFFF_FFFF;
      path_sum = run[31:0];
      if (path_sum > cur_spacing && wp_count < cur_wp_limit) begin
        outs[n] = make_wp(last_x, last_y, last_z, wp_count, 1'b0, 1'b1, 1'b0);
        n++;
        wp_count++;
        path_sum = seg[31:0];
      end
    end
    last_x = p.point_x;
    last_y = p.point_y;
    last_z = p.point_z;

    if (p.last_point) begin
      if (wp_count < cur_wp_limit && cur_pad) begin
        outs[n] = make_wp(p.point_x, p.point_y, p.point_z, wp_count, 1'b1, 1'b1, 1'b1);
        n++;
        wp_count++;
      end else if (n > 0) begin
        outs[n-1].end_of_path = 1'b1;
      end else begin
        // bare end marker
        outs[n] = make_wp('0, '0, '0, wp_count, 1'b0, 1'b0, 1'b1);
        n++;
      end
      last_x    = '0;
      last_y    = '0;
      last_z    = '0;
      path_sum  = '0;
      wp_count  = '0;
      path_open = 1'b0;
    end
    for (int i = 0; i < n; i++) expected_wps = {expected_wps, outs[i]};
  endfunction

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------
  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task automatic check_waypoint(pwd_pkg::waypoint_t got);
    pwd_pkg::waypoint_t want;
    if (expected_wps.size() == 0) begin
      flag_mismatch($sformatf("waypoint %h with none expected", got));
      return;
    end
    want = expected_wps.pop_front();
    compare_field("wp_x", 32'(got.wp_x), 32'(want.wp_x));
    compare_field("wp_y", 32'(got.wp_y), 32'(want.wp_y));
    compare_field("wp_z", 32'(got.wp_z), 32'(want.wp_z));
    compare_field("waypoint_index", 32'(got.waypoint_index), 32'(want.waypoint_index));
    compare_field("from_goal", 32'(got.from_goal), 32'(want.from_goal));
    compare_field("has_point", 32'(got.has_point), 32'(want.has_point));
    compare_field("end_of_path", 32'(got.end_of_path), 32'(want.end_of_path));
  endtask

  // Monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (wp_valid && wp_ready) begin
        check_waypoint(wp_data);
        rx_wait = draw_pause(rx_steady);
      end
      if (point_valid && point_ready) begin
        predict_waypoints(point_data);
        pt_accepted = 1'b1;
        pt_gap      = draw_pause(tx_steady);
      end
    end
  end

  // Driver: present the next point once the previous transaction is done
  always @(negedge clk) begin : point_driver
    logic nxt_valid;
    if (rst !== 1'b0) begin
      point_valid <= 1'b0;
    end else begin
      nxt_valid = point_valid;
      if (pt_accepted) begin
        nxt_valid   = 1'b0;
        pt_accepted = 1'b0;
      end
      if (!nxt_valid) begin
        if (pt_gap > 0) begin
          pt_gap--;
        end else if (pending_points.size() > 0) begin
          point_data <= pending_points.pop_front();
          nxt_valid = 1'b1;
        end
      end
      point_valid <= nxt_valid;
    end
  end

  // Receiver: random stall per result, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      wp_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      wp_ready <= 1'b0;
    end else begin
      wp_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(pwd_pkg::cfg_index_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pwd_pkg::CFG_SPACING_LIMIT:  cur_spacing  = val;
      pwd_pkg::CFG_WAYPOINT_LIMIT: cur_wp_limit = val[7:0];
      pwd_pkg::CFG_PAD_WITH_GOAL:  cur_pad      = val[0];
      default: ;
    endcase
  endtask

  task automatic queue_point(coord_t x, coord_t y, coord_t z, bit last);
    pwd_pkg::point_t p;
    p.point_x    = x;
    p.point_y    = y;
    p.point_z    = z;
    p.last_point = last;
    pending_points = {pending_points, p};
    gen_x = x;
    gen_y = y;
    gen_z = z;
  endtask

  // Signed step in [-span, span], wrapped to the coordinate width
  function automatic logic [CW-1:0] near_step(int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 2 * span) - span;
    return r[CW-1:0];
  endfunction

  // Whole paths: mostly short hops, some jumps anywhere, some repeats
  task automatic queue_random_paths(int goal);
    int          done, len, k, pick;
    int unsigned span;
    coord_t      nx, ny, nz;
    done = 0;
    while (done < goal) begin
      pick = $urandom_range(0, 19);
      if (pick < 3)       len = 1;
      else if (pick < 17) len = $urandom_range(2, 8);
      else                len = $urandom_range(9, 20);
      for (k = 0; k < len; k++) begin
        pick = $urandom_range(0, 9);
        span = ($urandom_range(0, 3) == 0) ? 100 : 1500;
        if (pick < 2) begin
          nx = coord_t'($urandom);
          ny = coord_t'($urandom);
          nz = coord_t'($urandom);
        end else if (pick == 2) begin
          nx = gen_x;
          ny = gen_y;
          nz = gen_z;
        end else begin
          nx = gen_x + near_step(span);
          ny = gen_y + near_step(span);
          nz = gen_z + near_step(span);
        end
        queue_point(nx, ny, nz, k == len - 1);
        done++;
      end
    end
  endtask

  // Wait until every point is taken and every result is in (or the drain limit
  // runs out), then let the block finish any point that yields no result
  task automatic wait_idle();
    int spent;
    spent = 0;
    while (pending_points.size() > 0 || point_valid) @(posedge clk);
    while (expected_wps.size() > 0 && spent < DRAIN_LIMIT) begin
      @(posedge clk);
      spent++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int k;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = pwd_pkg::CFG_SPACING_LIMIT;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: single point path, extreme jumps, short hops, sum equal to limit
    queue_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1);
    queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    queue_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1);
    queue_point(coord_t'(100), coord_t'(0), coord_t'(0), 1'b0);
    queue_point(coord_t'(200), coord_t'(0), coord_t'(0), 1'b0);
    queue_point(coord_t'(300), coord_t'(0), coord_t'(0), 1'b1);
    queue_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0);
    queue_point(coord_t'(1920), coord_t'(0), coord_t'(0), 1'b0);
    queue_point(coord_t'(1921), coord_t'(0), coord_t'(0), 1'b0);
    queue_point(coord_t'(1921), coord_t'(0), coord_t'(0), 1'b1);
    queue_random_paths(45);
    wait_idle();

    // Goal padding off: bare end marker
    write_reg(pwd_pkg::CFG_PAD_WITH_GOAL, $urandom & 32'hFFFF_FFFE);
    queue_point(coord_t'(10), coord_t'(10), coord_t'(10), 1'b0);
    queue_point(coord_t'(20), coord_t'(20), coord_t'(20), 1'b1);
    queue_random_paths(45);
    wait_idle();

    // Limit of one, then limit of zero
    write_reg(pwd_pkg::CFG_WAYPOINT_LIMIT, ($urandom & 32'hFFFF_FF00) | 32'd1);
    queue_point(coord_t'(-5), coord_t'(7), coord_t'(-9), 1'b1);
    wait_idle();
    write_reg(pwd_pkg::CFG_WAYPOINT_LIMIT, $urandom & 32'hFFFF_FF00);
    write_reg(pwd_pkg::CFG_PAD_WITH_GOAL, 32'd1);
    queue_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0);
    queue_point(COORD_MAX, COORD_MIN, coord_t'(0), 1'b0);
    queue_point(COORD_MIN, COORD_MAX, coord_t'(0), 1'b1);
    queue_random_paths(45);
    wait_idle();

    // Zero spacing, widest limit: a long path with a waypoint per segment
    write_reg(pwd_pkg::CFG_SPACING_LIMIT, 32'd0);
    write_reg(pwd_pkg::CFG_WAYPOINT_LIMIT, 32'd255);
    for (k = 0; k < 200; k++)
      queue_point(gen_x + near_step(1500), gen_y + near_step(1500),
                  gen_z + near_step(1500), k == 199);
    queue_random_paths(45);
    wait_idle();

    // Widest spacing, back to back: extreme swings drive the sum to saturation
    write_reg(pwd_pkg::CFG_SPACING_LIMIT, 32'hFFFF_FFFF);
    write_reg(pwd_pkg::CFG_WAYPOINT_LIMIT, 32'd4);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    for (k = 0; k < 160; k++) begin
      if (k % 2 == 0) queue_point(COORD_MAX, COORD_MAX, COORD_MAX, k == 159);
      else            queue_point(COORD_MIN, COORD_MIN, COORD_MIN, k == 159);
    end
    queue_random_paths(45);
    wait_idle();
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    // Random settings
    for (k = 0; k < 2; k++) begin
      write_reg(pwd_pkg::CFG_SPACING_LIMIT, $urandom_range(0, 4000));
      write_reg(pwd_pkg::CFG_WAYPOINT_LIMIT, $urandom_range(1, 8));
      write_reg(pwd_pkg::CFG_PAD_WITH_GOAL, $urandom_range(0, 1));
      queue_random_paths(30);
      wait_idle();
    end

    // Backpressure: receiver holds off while the sender keeps offering
    write_reg(pwd_pkg::CFG_SPACING_LIMIT, 32'd600);
    write_reg(pwd_pkg::CFG_WAYPOINT_LIMIT, 32'd6);
    write_reg(pwd_pkg::CFG_PAD_WITH_GOAL, 32'd1);
    tx_steady = 1'b1;
    queue_random_paths(45);
    @(posedge clk);
    hold_req = 1'b1;
    wait_idle();
    tx_steady = 1'b0;

    while (expected_wps.size() > 0) begin
      flag_mismatch($sformatf("waypoint %h never arrived", expected_wps[0]));
      void'(expected_wps.pop_front());
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### path_waypoint_decimator_top.f
design/pwd_pkg.sv
design/pwd_sqrt.sv
design/path_waypoint_decimator_top.sv
verif/path_waypoint_decimator_top_tb.sv
